// ===== rtl/psfq_pkg.sv =====
package psfq_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned ExpCntW = $clog2(MaxResults + 1);

  // command codes
  localparam logic [1:0] CmdEnqueue = 2'd0;
  localparam logic [1:0] CmdDequeue = 2'd1;
  localparam logic [1:0] CmdSweep   = 2'd2;

  // event codes
  localparam logic [2:0] EvQueued         = 3'd0;
  localparam logic [2:0] EvDropped        = 3'd1;
  localparam logic [2:0] EvQueueFull      = 3'd2;
  localparam logic [2:0] EvExpired        = 3'd3;
  localparam logic [2:0] EvDequeued       = 3'd4;
  localparam logic [2:0] EvDequeueEmpty   = 3'd5;
  localparam logic [2:0] EvNothingExpired = 3'd6;

  typedef struct packed {
    logic [1:0]  prio;
    logic [31:0] stamp;
    logic [15:0] src;
    logic [15:0] seq;
    logic [31:0] pay;
  } entry_t;

  // running best candidate of a scan
  typedef struct packed {
    logic        found;
    logic [1:0]  prio;
    logic [31:0] stamp;
  } best_t;

  // per-slot verdict of the compare unit
  typedef struct packed {
    logic dup;
    logic freeable;
    logic expired;
    logic better;
  } cmp_res_t;

endpackage

// ===== rtl/priority_store_forward_queue_top.sv =====
// Sequence: S_SCAN reads every slot through one compare unit, then S_DECIDE loads the
// only result itself; a dequeue hit adds S_EMIT_DEQ, a free-slot enqueue S_WRITE_NEW,
// a displacing enqueue S_EMIT_OLD then S_WRITE_NEW, a sweep S_SW_SEEK per slot through
// the last expired one plus S_SW_EMIT per result; stalls hold each emitting state.
// Throughput: one item at a time; in_stall_o is high until its last result is loaded.
// Reset: rst_ni async low clears valid bits, sequencer, output valid; lifetime 60000 ms.
module priority_store_forward_queue_top #(
  parameter int unsigned SLOTS           = 16,
  parameter int unsigned PRIORITY_LEVELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] now_ms_i,
  input  logic        is_data_i,
  input  logic [15:0] source_id_i,
  input  logic [15:0] sequence_number_i,
  input  logic [1:0]  priority_req_i,
  input  logic [31:0] payload_handle_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_code_o,
  output logic        accepted_o,
  output logic [15:0] out_source_o,
  output logic [15:0] out_sequence_o,
  output logic [1:0]  out_priority_o,
  output logic [31:0] out_payload_o,
  output logic        last_o,
  // lifetime register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import psfq_pkg::*;

  localparam int unsigned IdxW   = $clog2(SLOTS);
  localparam int unsigned CntW   = IdxW + 1;
  localparam int unsigned PriMax = (PRIORITY_LEVELS > 4) ? 3 : PRIORITY_LEVELS - 1;

  // sequencer
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_DECIDE    = 3'd2;
  localparam logic [2:0] S_EMIT_OLD  = 3'd3;
  localparam logic [2:0] S_WRITE_NEW = 3'd4;
  localparam logic [2:0] S_EMIT_DEQ  = 3'd5;
  localparam logic [2:0] S_SW_SEEK   = 3'd6;
  localparam logic [2:0] S_SW_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;

  // held item
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] now_q, now_d;
  logic        data_q, data_d;
  logic [15:0] src_q, src_d;
  logic [15:0] seq_q, seq_d;
  logic [1:0]  pri_q, pri_d;
  logic [31:0] pay_q, pay_d;
  logic [1:0]  pri_sat;

  logic [31:0] life_q, life_d;
  logic [SLOTS-1:0] slot_valid_q, slot_valid_d;

  // scan bookkeeping
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rv_q, rv_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic            dup_q, dup_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  best_t           best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [IdxW-1:0] pick_q, pick_d, pick_c;
  logic [SLOTS-1:0]   exp_mask_q, exp_mask_d;
  logic [ExpCntW-1:0] exp_cnt_q, exp_cnt_d;
  logic [ExpCntW-1:0] emitted_q, emitted_d;

  // output register
  logic        ov_q, ov_d;
  logic [2:0]  ev_q, ev_d;
  logic        acc_q, acc_d;
  logic [15:0] osrc_q, osrc_d;
  logic [15:0] oseq_q, oseq_d;
  logic [1:0]  opri_q, opri_d;
  logic [31:0] opay_q, opay_d;
  logic        olast_q, olast_d;
  logic        out_free;

  // memory and compare unit
  logic            mem_we;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_wdata;
  entry_t          rdata;
  cmp_res_t        res;

  psfq_store #(.SLOTS(SLOTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pick_q),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  psfq_cmp u_cmp (
    .cmd_i   (cmd_q),
    .entry_i (rdata),
    .valid_i (slot_valid_q[ridx_q]),
    .src_i   (src_q),
    .seq_i   (seq_q),
    .prio_i  (pri_q),
    .now_i   (now_q),
    .life_i  (life_q),
    .best_i  (best_q),
    .res_o   (res)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !ov_q || !out_stall_i;
  assign pri_sat     = (32'(priority_req_i) > PriMax) ? PriMax[1:0] : priority_req_i;
  assign pick_c      = (cmd_q == CmdEnqueue && free_found_q) ? free_idx_q : best_idx_q;

  always_comb begin
    mem_wdata.prio  = pri_q;
    mem_wdata.stamp = now_q;
    mem_wdata.src   = src_q;
    mem_wdata.seq   = seq_q;
    mem_wdata.pay   = pay_q;
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    now_d        = now_q;
    data_d       = data_q;
    src_d        = src_q;
    seq_d        = seq_q;
    pri_d        = pri_q;
    pay_d        = pay_q;
    life_d       = life_q;
    slot_valid_d = slot_valid_q;
    cnt_d        = cnt_q;
    rv_d         = 1'b0;
    ridx_d       = ridx_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    pick_d       = pick_q;
    exp_mask_d   = exp_mask_q;
    exp_cnt_d    = exp_cnt_q;
    emitted_d    = emitted_q;
    mem_we       = 1'b0;
    mem_raddr    = pick_q;
    ov_d         = (ov_q && !out_stall_i) ? 1'b0 : ov_q;
    ev_d         = ev_q;
    acc_d        = acc_q;
    osrc_d       = osrc_q;
    oseq_d       = oseq_q;
    opri_d       = opri_q;
    opay_d       = opay_q;
    olast_d      = olast_q;

    if (cfg_valid_i) begin
      life_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          now_d        = now_ms_i;
          data_d       = is_data_i;
          src_d        = source_id_i;
          seq_d        = sequence_number_i;
          pri_d        = pri_sat;
          pay_d        = payload_handle_i;
          cnt_d        = '0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          best_d.found = 1'b0;
          exp_mask_d   = '0;
          exp_cnt_d    = '0;
          if (command_i == CmdEnqueue || command_i == CmdDequeue ||
              command_i == CmdSweep) begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cnt_q != CntW'(SLOTS)) begin
          mem_raddr = cnt_q[IdxW-1:0];
          ridx_d    = cnt_q[IdxW-1:0];
          rv_d      = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end else if (!rv_q) begin
          state_d = S_DECIDE;
        end
        if (rv_q) begin
          if (cmd_q == CmdEnqueue) begin
            if (res.dup) dup_d = 1'b1;
            if (!free_found_q && res.freeable) begin
              free_found_d = 1'b1;
              free_idx_d   = ridx_q;
            end
          end
          if ((cmd_q == CmdEnqueue || cmd_q == CmdDequeue) && res.better) begin
            best_d.found = 1'b1;
            best_d.prio  = rdata.prio;
            best_d.stamp = rdata.stamp;
            best_idx_d   = ridx_q;
          end
          if (cmd_q == CmdSweep && slot_valid_q[ridx_q] && res.expired &&
              exp_cnt_q != ExpCntW'(MaxResults)) begin
            exp_mask_d[ridx_q] = 1'b1;
            exp_cnt_d          = exp_cnt_q + 1'b1;
          end
        end
      end

      S_DECIDE: begin
        mem_raddr = pick_c;
        if (cmd_q == CmdEnqueue) begin
          if (!data_q || dup_q || (!free_found_q && !best_q.found)) begin
            if (out_free) begin
              ov_d    = 1'b1;
              ev_d    = (!data_q || dup_q) ? EvDropped : EvQueueFull;
              acc_d   = 1'b0;
              osrc_d  = src_q;
              oseq_d  = seq_q;
              opri_d  = pri_q;
              opay_d  = pay_q;
              olast_d = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            pick_d  = pick_c;
            state_d = slot_valid_q[pick_c] ? S_EMIT_OLD : S_WRITE_NEW;
          end
        end else if (cmd_q == CmdDequeue) begin
          if (best_q.found) begin
            pick_d  = pick_c;
            state_d = S_EMIT_DEQ;
          end else if (out_free) begin
            ov_d    = 1'b1;
            ev_d    = EvDequeueEmpty;
            acc_d   = 1'b0;
            osrc_d  = '0;
            oseq_d  = '0;
            opri_d  = '0;
            opay_d  = '0;
            olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          if (exp_cnt_q != '0) begin
            cnt_d     = '0;
            emitted_d = '0;
            state_d   = S_SW_SEEK;
          end else if (out_free) begin
            ov_d    = 1'b1;
            ev_d    = EvNothingExpired;
            acc_d   = 1'b0;
            osrc_d  = '0;
            oseq_d  = '0;
            opri_d  = '0;
            opay_d  = '0;
            olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      S_EMIT_OLD: begin
        // displaced entry (expired or evicted) is reported first
        if (out_free) begin
          ov_d    = 1'b1;
          ev_d    = EvDropped;
          acc_d   = 1'b0;
          osrc_d  = rdata.src;
          oseq_d  = rdata.seq;
          opri_d  = rdata.prio;
          opay_d  = rdata.pay;
          olast_d = 1'b0;
          state_d = S_WRITE_NEW;
        end
      end

      S_WRITE_NEW: begin
        if (out_free) begin
          mem_we               = 1'b1;
          slot_valid_d[pick_q] = 1'b1;
          ov_d    = 1'b1;
          ev_d    = EvQueued;
          acc_d   = 1'b1;
          osrc_d  = src_q;
          oseq_d  = seq_q;
          opri_d  = pri_q;
          opay_d  = pay_q;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_EMIT_DEQ: begin
        if (out_free) begin
          slot_valid_d[pick_q] = 1'b0;
          ov_d    = 1'b1;
          ev_d    = EvDequeued;
          acc_d   = 1'b1;
          osrc_d  = rdata.src;
          oseq_d  = rdata.seq;
          opri_d  = rdata.prio;
          opay_d  = rdata.pay;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SW_SEEK: begin
        mem_raddr = cnt_q[IdxW-1:0];
        if (exp_mask_q[cnt_q[IdxW-1:0]]) begin
          pick_d  = cnt_q[IdxW-1:0];
          state_d = S_SW_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_SW_EMIT: begin
        if (out_free) begin
          slot_valid_d[pick_q] = 1'b0;
          exp_mask_d[pick_q]   = 1'b0;
          emitted_d = emitted_q + 1'b1;
          ov_d    = 1'b1;
          ev_d    = EvExpired;
          acc_d   = 1'b0;
          osrc_d  = rdata.src;
          oseq_d  = rdata.seq;
          opri_d  = rdata.prio;
          opay_d  = rdata.pay;
          olast_d = (emitted_q + 1'b1) == exp_cnt_q;
          if ((emitted_q + 1'b1) == exp_cnt_q) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_SW_SEEK;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      life_q       <= 32'd60000;
      slot_valid_q <= '0;
      rv_q         <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      life_q       <= life_d;
      slot_valid_q <= slot_valid_d;
      rv_q         <= rv_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    now_q        <= now_d;
    data_q       <= data_d;
    src_q        <= src_d;
    seq_q        <= seq_d;
    pri_q        <= pri_d;
    pay_q        <= pay_d;
    cnt_q        <= cnt_d;
    ridx_q       <= ridx_d;
    dup_q        <= dup_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    pick_q       <= pick_d;
    exp_mask_q   <= exp_mask_d;
    exp_cnt_q    <= exp_cnt_d;
    emitted_q    <= emitted_d;
    ev_q         <= ev_d;
    acc_q        <= acc_d;
    osrc_q       <= osrc_d;
    oseq_q       <= oseq_d;
    opri_q       <= opri_d;
    opay_q       <= opay_d;
    olast_q      <= olast_d;
  end

  assign out_valid_o    = ov_q;
  assign event_code_o   = ev_q;
  assign accepted_o     = acc_q;
  assign out_source_o   = osrc_q;
  assign out_sequence_o = oseq_q;
  assign out_priority_o = opri_q;
  assign out_payload_o  = opay_q;
  assign last_o         = olast_q;

endmodule

// ===== rtl/psfq_store.sv =====
module psfq_store #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(SLOTS)-1:0]     waddr_i,
  input  psfq_pkg::entry_t             wdata_i,
  input  logic [$clog2(SLOTS)-1:0]     raddr_i,
  output psfq_pkg::entry_t             rdata_o
);
  import psfq_pkg::*;

  entry_t mem [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/psfq_cmp.sv =====
module psfq_cmp (
  input  logic [1:0]         cmd_i,
  input  psfq_pkg::entry_t   entry_i,
  input  logic               valid_i,
  input  logic [15:0]        src_i,
  input  logic [15:0]        seq_i,
  input  logic [1:0]         prio_i,
  input  logic [31:0]        now_i,
  input  logic [31:0]        life_i,
  input  psfq_pkg::best_t    best_i,
  output psfq_pkg::cmp_res_t res_o
);
  import psfq_pkg::*;

  logic [31:0] age;
  logic        older;

  assign age   = now_i - entry_i.stamp;   // wraps mod 2^32
  assign older = (entry_i.prio == best_i.prio) && (entry_i.stamp < best_i.stamp);

  always_comb begin
    res_o.dup      = valid_i && (entry_i.src == src_i) && (entry_i.seq == seq_i);
    res_o.expired  = age >= life_i;
    res_o.freeable = !valid_i || res_o.expired;
    res_o.better   = 1'b0;
    if (cmd_i == CmdEnqueue) begin
      // eviction victim: highest priority value not below incoming, oldest
      res_o.better = (entry_i.prio >= prio_i) &&
                     (!best_i.found || (entry_i.prio > best_i.prio) || older);
    end else if (cmd_i == CmdDequeue) begin
      res_o.better = valid_i &&
                     (!best_i.found || (entry_i.prio < best_i.prio) || older);
    end
  end

endmodule

// ===== sim/tb_priority_store_forward_queue_top.sv =====
module tb_priority_store_forward_queue_top;
  import psfq_pkg::*;

  localparam int unsigned NSLOT = 16;
  localparam int unsigned WDOG_LIMIT = 20000;

  // one queue event as seen on the result port
  typedef struct packed {
    logic [2:0]  code;
    logic        acc;
    logic [15:0] src;
    logic [15:0] seq;
    logic [1:0]  prio;
    logic [31:0] pay;
    logic        last;
  } qevent_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CmdEnqueue;
  logic [31:0] now_ms_i = '0;
  logic        is_data_i = 1'b0;
  logic [15:0] source_id_i = '0;
  logic [15:0] sequence_number_i = '0;
  logic [1:0]  priority_req_i = '0;
  logic [31:0] payload_handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_code_o;
  logic        accepted_o;
  logic [15:0] out_source_o;
  logic [15:0] out_sequence_o;
  logic [1:0]  out_priority_o;
  logic [31:0] out_payload_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  priority_store_forward_queue_top DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .command_i, .now_ms_i, .is_data_i,
    .source_id_i, .sequence_number_i, .priority_req_i, .payload_handle_i,
    .out_valid_o, .out_stall_i, .event_code_o, .accepted_o, .out_source_o,
    .out_sequence_o, .out_priority_o, .out_payload_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // shadow of the slot table
  logic [31:0] life_ms;
  logic        sh_valid [NSLOT];
  logic [1:0]  sh_prio  [NSLOT];
  logic [31:0] sh_stamp [NSLOT];
  logic [15:0] sh_src   [NSLOT];
  logic [15:0] sh_seq   [NSLOT];
  logic [31:0] sh_pay   [NSLOT];

  qevent_t pending_events[$];
  int      n_errors = 0;
  int      send_idle_pct = 0;  // percent of cycles the sender idles
  int      recv_stall_pct = 0; // percent of cycles the receiver stalls
  int      quiet_cycles = 0;
  logic [31:0] clock_ms = 32'd1000;

  function automatic qevent_t mk_event(logic [2:0] c, logic a, logic [15:0] s,
                                       logic [15:0] q, logic [1:0] p, logic [31:0] y);
    qevent_t e;
    e.code = c; e.acc = a; e.src = s; e.seq = q; e.prio = p; e.pay = y; e.last = 1'b0;
    return e;
  endfunction

  function automatic logic aged_out(int i, logic [31:0] now);
    logic [31:0] age;
    age = now - sh_stamp[i];
    return age >= life_ms;
  endfunction

  // computes the events of one command and updates the shadow table
  task automatic predict_queue(logic [1:0] cmd, logic [31:0] now, logic dat,
                               logic [15:0] s, logic [15:0] q, logic [1:0] p,
                               logic [31:0] y);
    qevent_t evs[$];
    logic dup;
    int pick;
    dup = 1'b0;
    pick = -1;
    if (cmd == CmdEnqueue) begin
      for (int i = 0; i < NSLOT; i++)
        if (sh_valid[i] && sh_src[i] == s && sh_seq[i] == q) dup = 1'b1;
      if (!dat || dup) begin
        evs.push_back(mk_event(EvDropped, 1'b0, s, q, p, y));
      end else begin
        for (int i = 0; i < NSLOT && pick < 0; i++)
          if (!sh_valid[i] || aged_out(i, now)) pick = i;
        // victim search covers every slot; all are valid here
        if (pick < 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (sh_prio[i] < p) continue;
            if (pick < 0 || sh_prio[i] > sh_prio[pick] ||
                (sh_prio[i] == sh_prio[pick] && sh_stamp[i] < sh_stamp[pick]))
              pick = i;
          end
        end
        if (pick < 0) begin
          evs.push_back(mk_event(EvQueueFull, 1'b0, s, q, p, y));
        end else begin
          if (sh_valid[pick])
            evs.push_back(mk_event(EvDropped, 1'b0, sh_src[pick], sh_seq[pick],
                                   sh_prio[pick], sh_pay[pick]));
          sh_valid[pick] = 1'b1; sh_prio[pick] = p; sh_stamp[pick] = now;
          sh_src[pick] = s; sh_seq[pick] = q; sh_pay[pick] = y;
          evs.push_back(mk_event(EvQueued, 1'b1, s, q, p, y));
        end
      end
    end else if (cmd == CmdDequeue) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!sh_valid[i]) continue;
        if (pick < 0 || sh_prio[i] < sh_prio[pick] ||
            (sh_prio[i] == sh_prio[pick] && sh_stamp[i] < sh_stamp[pick]))
          pick = i;
      end
      if (pick < 0) begin
        evs.push_back(mk_event(EvDequeueEmpty, 1'b0, '0, '0, '0, '0));
      end else begin
        evs.push_back(mk_event(EvDequeued, 1'b1, sh_src[pick], sh_seq[pick],
                               sh_prio[pick], sh_pay[pick]));
        sh_valid[pick] = 1'b0;
      end
    end else if (cmd == CmdSweep) begin
      for (int i = 0; i < NSLOT && evs.size() < MaxResults; i++)
        if (sh_valid[i] && aged_out(i, now)) begin
          evs.push_back(mk_event(EvExpired, 1'b0, sh_src[i], sh_seq[i],
                                 sh_prio[i], sh_pay[i]));
          sh_valid[i] = 1'b0;
        end
      if (evs.size() == 0)
        evs.push_back(mk_event(EvNothingExpired, 1'b0, '0, '0, '0, '0));
    end
    // unused command code: nothing comes back
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // drive one item and wait for it to be taken
  task automatic send_item(logic [1:0] cmd, logic [31:0] now, logic dat,
                           logic [15:0] s, logic [15:0] q, logic [1:0] p,
                           logic [31:0] y);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    command_i <= cmd; now_ms_i <= now; is_data_i <= dat; source_id_i <= s;
    sequence_number_i <= q; priority_req_i <= p; payload_handle_i <= y;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_queue(cmd, now, dat, s, q, p, y);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_queue();
    while (pending_events.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_lifetime(logic [31:0] v);
    drain_queue();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    life_ms = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    qevent_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {event_code_o, accepted_o, out_source_o, out_sequence_o,
             out_priority_o, out_payload_o, last_o};
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.code), 32'd0);
      end else begin
        want = pending_events.pop_front();
        if (got.code !== want.code)
          report_mismatch("event_code", 32'(got.code), 32'(want.code));
        if (got.acc !== want.acc)
          report_mismatch("accepted", 32'(got.acc), 32'(want.acc));
        if (got.src !== want.src)
          report_mismatch("out_source", 32'(got.src), 32'(want.src));
        if (got.seq !== want.seq)
          report_mismatch("out_sequence", 32'(got.seq), 32'(want.seq));
        if (got.prio !== want.prio)
          report_mismatch("out_priority", 32'(got.prio), 32'(want.prio));
        if (got.pay !== want.pay) report_mismatch("out_payload", got.pay, want.pay);
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // directed: extremes, every command, dup, refusal, full table, eviction
  task automatic test_directed();
    send_item(CmdDequeue, clock_ms, 1'b1, 16'h0, 16'h0, 2'd0, 32'h0);
    send_item(CmdSweep, clock_ms, 1'b0, 16'h0, 16'h0, 2'd0, 32'h0);
    send_item(CmdEnqueue, clock_ms, 1'b0, 16'hFFFF, 16'hFFFF, 2'd3, 32'hFFFFFFFF);
    send_item(2'd3, clock_ms, 1'b1, 16'h1, 16'h1, 2'd1, 32'h1);
    for (int i = 0; i < NSLOT; i++)
      send_item(CmdEnqueue, clock_ms + 32'(i), 1'b1, 16'(16'hFFFF - i), 16'(i),
                2'(i % 4), $urandom);
    send_item(CmdEnqueue, clock_ms, 1'b1, 16'hFFFF, 16'h0, 2'd0, 32'h0); // duplicate
    send_item(CmdEnqueue, clock_ms + 20, 1'b1, 16'h0, 16'h0, 2'd3, 32'h5); // evicts
    send_item(CmdDequeue, clock_ms + 21, 1'b1, 16'h0, 16'h0, 2'd0, 32'h0);
    clock_ms = clock_ms + 100;
  endtask

  task automatic test_lifetime_extremes();
    write_lifetime(32'd0); // everything is expired at once
    send_item(CmdEnqueue, 32'hFFFFFFFF, 1'b1, 16'h1234, 16'h1, 2'd2, 32'hA5A5A5A5);
    send_item(CmdSweep, 32'h0, 1'b1, 16'h0, 16'h0, 2'd0, 32'h0);
    write_lifetime(32'hFFFFFFFF);
    send_item(CmdSweep, 32'h0, 1'b1, 16'h0, 16'h0, 2'd0, 32'h0);
  endtask

  // mostly enqueues on a small id space so duplicates and evictions happen
  task automatic test_random(int n_items, logic [31:0] life);
    int r;
    write_lifetime(life);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(40);
      if (r < 3) clock_ms = $urandom; // jumps, wraps included
      if (r < 60)
        send_item(CmdEnqueue, clock_ms, ($urandom_range(9) != 0),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7)),
                  2'($urandom), $urandom);
      else if (r < 80)
        send_item(CmdDequeue, clock_ms, 1'($urandom), 16'($urandom), 16'($urandom),
                  2'($urandom), $urandom);
      else if (r < 97)
        send_item(CmdSweep, clock_ms, 1'($urandom), 16'($urandom), 16'($urandom),
                  2'($urandom), $urandom);
      else
        send_item(2'd3, clock_ms, 1'($urandom), 16'($urandom), 16'($urandom),
                  2'($urandom), $urandom);
    end
  endtask

  initial begin
    life_ms = 32'd60000;
    foreach (sh_valid[i]) begin
      sh_valid[i] = 1'b0; sh_prio[i] = '0; sh_stamp[i] = '0;
      sh_src[i] = '0; sh_seq[i] = '0; sh_pay[i] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_lifetime_extremes();
    send_idle_pct = 9; recv_stall_pct = 84;
    test_random(120, 32'd150);
    send_idle_pct = 84; recv_stall_pct = 9;
    test_random(120, 32'd60000);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(130, 32'd300);

    drain_queue();
    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== priority_store_forward_queue_top.f =====
rtl/psfq_pkg.sv
rtl/psfq_store.sv
rtl/psfq_cmp.sv
rtl/priority_store_forward_queue_top.sv
sim/tb_priority_store_forward_queue_top.sv
